### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/siu_pkg.sv
// types, constants and helper functions of the uneven simpson integrator
package siu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int K_SHIFT   = 32 - FRAC_BITS;

   localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [31:0] SPACING_RESET = 32'h0001_0000;

   typedef enum logic {
      CSR_USE_POSITIONS   = 1'b0,
      CSR_UNIFORM_SPACING = 1'b1
   } csr_index_type;

   // operand sets of the multiply-shift-divide unit
   typedef enum logic [3:0] {
      OP_PW0, OP_PW2, OP_PSK, OP_EV2, OP_EV1, OP_EHK, OP_TRP, OP_SY0, OP_SY1, OP_SY2
   } msd_op_type;

   typedef enum logic [1:0] {
      DIV_REAL, DIV_ONE, DIV_F, DIV_F1
   } div_mode_type;

   typedef enum logic [1:0] {
      UOP_MSD, UOP_ALU, UOP_DONE
   } uop_kind_type;

   typedef enum logic [1:0] {
      TERM_PAIR, TERM_END, TERM_TRAP
   } term_type;

   typedef struct packed {
      uop_kind_type kind;
      msd_op_type   op;
      logic         sub;
      logic [1:0]   src_a;
      logic [1:0]   src_b;
      logic [1:0]   dst;
   } uop_type;

   typedef struct packed {
      logic    capture;
      logic    plan_clear;
      logic    mark_zero;
      logic    msd_start;
      logic    alu_en;
      logic    commit;
      logic    emit;
      uop_type uop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic seen_ge2;
      logic parity;
      logic h0_zero;
      logic h1_zero;
      logic s_zero;
      logic msd_done;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic              sat;
      logic signed [63:0] value;
   } sat_res_type;

   function automatic sat_res_type sat_add(logic signed [63:0] a, logic signed [63:0] b);
      sat_res_type r;
      logic signed [63:0] s;
      s = a + b;
      r.sat = (a[63] == b[63]) && (s[63] != a[63]);
      r.value = r.sat ? (a[63] ? INT64_MIN : INT64_MAX) : s;
      return r;
   endfunction

   function automatic sat_res_type sat_sub(logic signed [63:0] a, logic signed [63:0] b);
      sat_res_type r;
      if (b == INT64_MIN) begin
         r.sat = 1'b1;
         r.value = a[63] ? (a + INT64_MIN) : INT64_MAX;
      end else begin
         r = sat_add(a, -b);
      end
      return r;
   endfunction

   function automatic uop_type uop_msd(msd_op_type op, logic [1:0] src, logic [1:0] dst);
      uop_type u;
      u = '{kind: UOP_MSD, op: op, sub: 1'b0, src_a: src, src_b: 2'd0, dst: dst};
      return u;
   endfunction

   function automatic uop_type uop_alu(logic sub, logic [1:0] a, logic [1:0] b,
                                       logic [1:0] dst);
      uop_type u;
      u = '{kind: UOP_ALU, op: OP_PSK, sub: sub, src_a: a, src_b: b, dst: dst};
      return u;
   endfunction

   // step sequences of the three terms, temps t0..t3
   function automatic uop_type get_uop(term_type term, logic [3:0] step);
      uop_type u;
      u = '{kind: UOP_DONE, op: OP_PSK, sub: 1'b0, src_a: 2'd0, src_b: 2'd0, dst: 2'd0};
      unique case (term)
         TERM_PAIR: begin
            unique case (step)
               4'd0: u = uop_msd(OP_PW0, 2'd0, 2'd0);
               4'd1: u = uop_msd(OP_PW2, 2'd0, 2'd2);
               4'd2: u = uop_msd(OP_PSK, 2'd0, 2'd1);
               4'd3: u = uop_alu(1'b1, 2'd1, 2'd0, 2'd1);
               4'd4: u = uop_alu(1'b1, 2'd1, 2'd2, 2'd1);
               4'd5: u = uop_msd(OP_SY0, 2'd0, 2'd0);
               4'd6: u = uop_msd(OP_SY1, 2'd1, 2'd1);
               4'd7: u = uop_msd(OP_SY2, 2'd2, 2'd2);
               4'd8: u = uop_alu(1'b0, 2'd0, 2'd1, 2'd0);
               4'd9: u = uop_alu(1'b0, 2'd0, 2'd2, 2'd0);
               default: ;
            endcase
         end
         TERM_END: begin
            unique case (step)
               4'd0: u = uop_msd(OP_EV2, 2'd0, 2'd2);
               4'd1: u = uop_msd(OP_EV1, 2'd0, 2'd1);
               4'd2: u = uop_msd(OP_EHK, 2'd0, 2'd0);
               4'd3: u = uop_alu(1'b0, 2'd2, 2'd1, 2'd3);
               4'd4: u = uop_alu(1'b1, 2'd3, 2'd0, 2'd0);
               4'd5: u = uop_msd(OP_SY2, 2'd2, 2'd2);
               4'd6: u = uop_msd(OP_SY1, 2'd1, 2'd1);
               4'd7: u = uop_msd(OP_SY0, 2'd0, 2'd0);
               4'd8: u = uop_alu(1'b0, 2'd2, 2'd1, 2'd1);
               4'd9: u = uop_alu(1'b1, 2'd1, 2'd0, 2'd0);
               default: ;
            endcase
         end
         TERM_TRAP: begin
            unique case (step)
               4'd0: u = uop_msd(OP_TRP, 2'd0, 2'd0);
               default: ;
            endcase
         end
         default: ;
      endcase
      return u;
   endfunction

endpackage

### hw/rtl/siu_muldiv.sv
// sequential signed (a*b << k) / d, or (a*b << k) >> s with s of 0, FRAC_BITS or FRAC_BITS + 1, truncated and saturated
module siu_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [63:0]    op_a,
   input  logic signed [63:0]    op_b,
   input  logic signed [63:0]    op_d,
   input  siu_pkg::div_mode_type div_mode,
   input  logic                  k_en,
   output logic                  done,
   output logic signed [63:0]    result,
   output logic                  sat
);
   import siu_pkg::*;

   localparam int DIV_STEPS = 128;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [5:0] {
      MD_IDLE  = 6'b000001,
      MD_MUL   = 6'b000010,
      MD_CHECK = 6'b000100,
      MD_POW   = 6'b001000,
      MD_DIV   = 6'b010000,
      MD_FIN   = 6'b100000
   } md_state_type;

   function automatic logic [63:0] mag64(logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   md_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, k_ff, k_in, ovf_ff, ovf_in, zero_ff, zero_in, fsat_ff, fsat_in;
   logic [63:0] ua_ff, ua_in, ub_ff, ub_in, ud_ff, ud_in, rem_ff, rem_in, q_ff, q_in;
   logic [127:0] acc_ff, acc_in;
   div_mode_type mode_ff, mode_in;

   logic [31:0]  a_part, b_part;
   logic [63:0]  pp;
   logic [127:0] pp_al, pow_q;
   logic [64:0]  rem_sh;
   logic         ge;
   logic [63:0]  limit;
   logic         over;

   assign a_part = cnt_ff[0] ? ua_ff[63:32] : ua_ff[31:0];
   assign b_part = cnt_ff[1] ? ub_ff[63:32] : ub_ff[31:0];
   assign pp     = a_part * b_part;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    pp_al = {64'd0, pp};
         2'd3:    pp_al = {pp, 64'd0};
         default: pp_al = {32'd0, pp, 32'd0};
      endcase
   end

   always_comb begin
      unique case (mode_ff)
         DIV_F:   pow_q = acc_ff >> FRAC_BITS;
         DIV_F1:  pow_q = acc_ff >> (FRAC_BITS + 1);
         default: pow_q = acc_ff;
      endcase
   end

   // restoring division, one quotient bit a cycle
   assign rem_sh = {rem_ff, acc_ff[127]};
   assign ge     = rem_sh >= {1'b0, ud_ff};

   assign limit  = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
   assign over   = fsat_ff || ovf_ff || (q_ff > limit);
   assign done   = (state_ff == MD_FIN);
   assign sat    = !zero_ff && over;
   assign result = zero_ff ? 64'sd0 :
                   over    ? (neg_ff ? INT64_MIN : INT64_MAX) :
                   neg_ff  ? -$signed(q_ff) : $signed(q_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      ovf_in   = ovf_ff;
      zero_in  = zero_ff;
      fsat_in  = fsat_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      ud_in    = ud_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      acc_in   = acc_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               neg_in   = op_a[63] ^ op_b[63] ^ ((div_mode == DIV_REAL) & op_d[63]);
               ua_in    = mag64(op_a);
               ub_in    = mag64(op_b);
               ud_in    = mag64(op_d);
               mode_in  = div_mode;
               k_in     = k_en;
               acc_in   = '0;
               cnt_in   = '0;
               ovf_in   = 1'b0;
               zero_in  = 1'b0;
               fsat_in  = 1'b0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            acc_in = acc_ff + pp_al;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = MD_CHECK;
            end
         end
         MD_CHECK: begin
            priority if (mode_ff == DIV_REAL && ud_ff == 64'd0) begin
               zero_in  = 1'b1;
               state_in = MD_FIN;
            end else if (k_ff && acc_ff[127 -: K_SHIFT] != '0) begin
               fsat_in  = 1'b1;
               state_in = MD_FIN;
            end else begin
               if (k_ff) begin
                  acc_in = acc_ff << K_SHIFT;
               end
               cnt_in   = '0;
               rem_in   = '0;
               q_in     = '0;
               state_in = (mode_ff == DIV_REAL) ? MD_DIV : MD_POW;
            end
         end
         MD_POW: begin
            q_in     = pow_q[63:0];
            ovf_in   = |pow_q[127:64];
            state_in = MD_FIN;
         end
         MD_DIV: begin
            rem_in = ge ? 64'(rem_sh - {1'b0, ud_ff}) : rem_sh[63:0];
            acc_in = acc_ff << 1;
            q_in   = {q_ff[62:0], ge};
            ovf_in = ovf_ff | q_ff[63];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = MD_FIN;
            end
         end
         MD_FIN: begin
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      k_ff    <= k_in;
      ovf_ff  <= ovf_in;
      zero_ff <= zero_in;
      fsat_ff <= fsat_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      ud_ff   <= ud_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      acc_ff  <= acc_in;
      mode_ff <= mode_in;
   end

endmodule

### hw/rtl/siu_datapath.sv
// window, running sum, temporaries, config registers, multiply-shift-divide unit and output register
module siu_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  siu_pkg::ctrl_cmd_type  cmd,
   output siu_pkg::dp_status_type status,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wr_data,
   input  logic signed [31:0]     req_sample_value,
   input  logic signed [31:0]     req_position,
   input  logic                   req_last_sample,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic signed [63:0]     rsp_integral,
   output logic                   rsp_zero_spacing,
   output logic                   rsp_saturated
);
   import siu_pkg::*;

   logic use_pos_ff, use_pos_in;
   logic [31:0] spacing_ff, spacing_in;
   logic signed [31:0] ws0_ff, ws0_in, ws1_ff, ws1_in, prev_ff, prev_in;
   logic signed [32:0] sp1_ff, sp1_in;
   logic [1:0] seen_ff, seen_in, err_ff, err_in;
   logic parity_ff, parity_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [31:0] y_ff, y_in, pos_ff, pos_in;
   logic last_ff, last_in;
   logic signed [32:0] h_ff, h_in;
   logic signed [63:0] t_ff [4];
   logic signed [63:0] t_in [4];
   logic [1:0] dst_ff, dst_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] integral_ff, integral_in;
   logic zs_ff, zs_in, sat_ff, sat_in;

   logic signed [32:0] h_new;
   logic signed [63:0] h0x, h1x, sx, y0x, y1x, y2x, t_sel;
   logic signed [63:0] op_a, op_b, op_d;
   div_mode_type div_mode;
   logic k_en;
   logic md_done, md_sat;
   logic signed [63:0] md_result;
   sat_res_type alu_res, sum_res;

   // spacing before the sample being captured
   assign h_new = use_pos_ff ? ({req_position[31], req_position} - {prev_ff[31], prev_ff})
                             : {1'b0, spacing_ff};

   assign h0x = {{31{sp1_ff[32]}}, sp1_ff};
   assign h1x = {{31{h_ff[32]}}, h_ff};
   assign sx  = h0x + h1x;
   assign y0x = {{32{ws0_ff[31]}}, ws0_ff};
   assign y1x = {{32{ws1_ff[31]}}, ws1_ff};
   assign y2x = {{32{y_ff[31]}}, y_ff};
   assign t_sel = t_ff[cmd.uop.src_a];

   always_comb begin
      op_a     = sx;
      op_b     = 64'sd1;
      op_d     = 64'sd1;
      div_mode = DIV_ONE;
      k_en     = 1'b1;
      unique case (cmd.uop.op)
         OP_PW0: begin
            op_b     = (h0x <<< 1) - h1x;
            op_d     = (h0x <<< 2) + (h0x <<< 1);
            div_mode = DIV_REAL;
         end
         OP_PW2: begin
            op_b     = (h1x <<< 1) - h0x;
            op_d     = (h1x <<< 2) + (h1x <<< 1);
            div_mode = DIV_REAL;
         end
         OP_PSK: ;
         OP_EV2: begin
            op_a     = h1x;
            op_b     = (h1x <<< 1) + (h0x <<< 1) + h0x;
            op_d     = (sx <<< 2) + (sx <<< 1);
            div_mode = DIV_REAL;
         end
         OP_EV1: begin
            op_a     = h1x;
            op_b     = h1x + (h0x <<< 1) + h0x;
            op_d     = (h0x <<< 2) + (h0x <<< 1);
            div_mode = DIV_REAL;
         end
         OP_EHK: op_a = h1x;
         OP_TRP: begin
            op_a     = y1x + y2x;
            op_b     = h1x;
            div_mode = DIV_F1;
         end
         OP_SY0: begin
            op_a     = t_sel;
            op_b     = y0x;
            div_mode = DIV_F;
            k_en     = 1'b0;
         end
         OP_SY1: begin
            op_a     = t_sel;
            op_b     = y1x;
            div_mode = DIV_F;
            k_en     = 1'b0;
         end
         OP_SY2: begin
            op_a     = t_sel;
            op_b     = y2x;
            div_mode = DIV_F;
            k_en     = 1'b0;
         end
         default: ;
      endcase
   end

   siu_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.msd_start),
      .op_a     (op_a),
      .op_b     (op_b),
      .op_d     (op_d),
      .div_mode (div_mode),
      .k_en     (k_en),
      .done     (md_done),
      .result   (md_result),
      .sat      (md_sat)
   );

   assign alu_res = cmd.uop.sub ? sat_sub(t_ff[cmd.uop.src_a], t_ff[cmd.uop.src_b])
                                : sat_add(t_ff[cmd.uop.src_a], t_ff[cmd.uop.src_b]);
   assign sum_res = sat_add(sum_ff, t_ff[0]);

   always_comb begin
      use_pos_in   = use_pos_ff;
      spacing_in   = spacing_ff;
      ws0_in       = ws0_ff;
      ws1_in       = ws1_ff;
      prev_in      = prev_ff;
      sp1_in       = sp1_ff;
      seen_in      = seen_ff;
      err_in       = err_ff;
      parity_in    = parity_ff;
      sum_in       = sum_ff;
      y_in         = y_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      h_in         = h_ff;
      t_in         = t_ff;
      dst_in       = dst_ff;
      rsp_valid_in = rsp_valid_ff;
      integral_in  = integral_ff;
      zs_in        = zs_ff;
      sat_in       = sat_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_USE_POSITIONS:   use_pos_in = csr_wr_data[0];
            CSR_UNIFORM_SPACING: spacing_in = csr_wr_data;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         y_in    = req_sample_value;
         pos_in  = req_position;
         last_in = req_last_sample;
         h_in    = h_new;
      end

      if (cmd.plan_clear) begin
         t_in[0] = 64'sd0;
      end
      if (cmd.mark_zero) begin
         err_in[0] = 1'b1;
      end
      if (cmd.msd_start) begin
         dst_in = cmd.uop.dst;
      end
      if (md_done) begin
         t_in[dst_ff] = md_result;
         if (md_sat) begin
            err_in[1] = 1'b1;
         end
      end
      if (cmd.alu_en) begin
         t_in[cmd.uop.dst] = alu_res.value;
         if (alu_res.sat) begin
            err_in[1] = 1'b1;
         end
      end

      if (cmd.commit) begin
         prev_in = pos_ff;
         if (seen_ff == 2'd0) begin
            ws1_in  = y_ff;
            seen_in = 2'd1;
         end else begin
            sum_in    = sum_res.value;
            if (sum_res.sat) begin
               err_in[1] = 1'b1;
            end
            ws0_in    = ws1_ff;
            ws1_in    = y_ff;
            sp1_in    = h_ff;
            parity_in = ~parity_ff;
            if (seen_ff != 2'd3) begin
               seen_in = seen_ff + 2'd1;
            end
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         integral_in  = sum_ff;
         zs_in        = err_ff[0];
         sat_in       = err_ff[1];
         ws0_in       = '0;
         ws1_in       = '0;
         prev_in      = '0;
         sp1_in       = '0;
         seen_in      = '0;
         parity_in    = 1'b0;
         sum_in       = '0;
         err_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_pos_ff   <= 1'b0;
         spacing_ff   <= SPACING_RESET;
         ws0_ff       <= '0;
         ws1_ff       <= '0;
         prev_ff      <= '0;
         sp1_ff       <= '0;
         seen_ff      <= '0;
         err_ff       <= '0;
         parity_ff    <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         use_pos_ff   <= use_pos_in;
         spacing_ff   <= spacing_in;
         ws0_ff       <= ws0_in;
         ws1_ff       <= ws1_in;
         prev_ff      <= prev_in;
         sp1_ff       <= sp1_in;
         seen_ff      <= seen_in;
         err_ff       <= err_in;
         parity_ff    <= parity_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      h_ff        <= h_in;
      t_ff        <= t_in;
      dst_ff      <= dst_in;
      integral_ff <= integral_in;
      zs_ff       <= zs_in;
      sat_ff      <= sat_in;
   end

   assign status.first    = (seen_ff == 2'd0);
   assign status.last     = last_ff;
   assign status.seen_ge2 = seen_ff[1];
   assign status.parity   = parity_ff;
   assign status.h0_zero  = (sp1_ff == 33'sd0);
   assign status.h1_zero  = (h_ff == 33'sd0);
   assign status.s_zero   = (sx == 64'sd0);
   assign status.msd_done = md_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_integral     = integral_ff;
   assign rsp_zero_spacing = zs_ff;
   assign rsp_saturated    = sat_ff;

endmodule

### hw/rtl/siu_ctrl.sv
// controller: request intake, term selection and step sequencing
module siu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  siu_pkg::dp_status_type status,
   output siu_pkg::ctrl_cmd_type  cmd
);
   import siu_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PLAN   = 6'b000010,
      ST_ISSUE  = 6'b000100,
      ST_WAIT   = 6'b001000,
      ST_COMMIT = 6'b010000,
      ST_EMIT   = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   term_type term_ff, term_in;
   logic [3:0] step_ff, step_in;
   uop_type uop;
   logic par_next;

   assign uop       = get_uop(term_ff, step_ff);
   assign par_next  = ~status.parity;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PLAN;
            end
         end
         ST_PLAN: begin
            cmd.plan_clear = 1'b1;
            step_in        = 4'd0;
            priority if (status.first) begin
               state_in = ST_COMMIT;
            end else if (status.seen_ge2 && !par_next) begin
               if (status.h0_zero || status.h1_zero) begin
                  cmd.mark_zero = 1'b1;
                  state_in      = ST_COMMIT;
               end else begin
                  term_in  = TERM_PAIR;
                  state_in = ST_ISSUE;
               end
            end else if (status.last && par_next && status.seen_ge2) begin
               if (status.h0_zero || status.s_zero) begin
                  cmd.mark_zero = 1'b1;
                  state_in      = ST_COMMIT;
               end else begin
                  term_in  = TERM_END;
                  state_in = ST_ISSUE;
               end
            end else if (status.last && par_next) begin
               term_in  = TERM_TRAP;
               state_in = ST_ISSUE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_ISSUE: begin
            cmd.uop = uop;
            unique case (uop.kind)
               UOP_MSD: begin
                  cmd.msd_start = 1'b1;
                  state_in      = ST_WAIT;
               end
               UOP_ALU: begin
                  cmd.alu_en = 1'b1;
                  step_in    = step_ff + 4'd1;
               end
               default: state_in = ST_COMMIT;
            endcase
         end
         ST_WAIT: begin
            cmd.uop = uop;
            if (status.msd_done) begin
               step_in  = step_ff + 4'd1;
               state_in = ST_ISSUE;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= TERM_PAIR;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         step_ff  <= step_in;
      end
   end

endmodule

### hw/rtl/simpson_integrator_uneven.sv
// top level of the streaming uneven-spacing simpson integrator
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   sample_value, position, last_sample
//   rsp      out        rsp_valid/rsp_stall   integral, zero_spacing, saturated
//   csr      in         csr_wr_en             csr_index, csr_wr_data
//
// a request that closes no term passes through take, plan and commit
// a trapezoid request runs one short multiply-and-shift pass; a pair term or end correction
//   runs two real divisions of 128 bit-serial steps in the shared divider,
//   plus four short multiply-and-shift passes and four add steps
// the last request of a set adds an emit step that loads the output register once it is free
// reset is synchronous; it clears the stream state and the position-mode flag and sets the spacing to SPACING_RESET
// a waiting result holds only its own register; the next request is taken meanwhile
`include "assert_macros.svh"
module simpson_integrator_uneven (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_position,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_integral,
   output logic               rsp_zero_spacing,
   output logic               rsp_saturated,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [31:0]        csr_wr_data
);
   import siu_pkg::*;

   // commands down, status up
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // controller: picks the term for each request and walks its steps
   siu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: window, sums, divider and output register
   siu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_sample_value (req_sample_value),
      .req_position     (req_position),
      .req_last_sample  (req_last_sample),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_integral     (rsp_integral),
      .rsp_zero_spacing (rsp_zero_spacing),
      .rsp_saturated    (rsp_saturated)
   );

   // a result is only loaded into a free output register
   `ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, status.out_free)
   // the divider never finishes the cycle after it starts
   `ASSERT_NEXT(a_msd_latency, clock, reset, cmd.msd_start, !status.msd_done)
   // a taken request keeps the block busy in the next cycle
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

endmodule

### dv/simpson_integrator_uneven_tb.sv
// testbench of the streaming uneven-spacing simpson integrator
`timescale 1ns / 1ps
module simpson_integrator_uneven_tb;
   import siu_pkg::*;

   typedef logic signed [63:0] s64_type;

   // one request: a sample with its abscissa and the end-of-set mark
   typedef struct {
      logic signed [31:0] value;
      logic signed [31:0] pos;
      logic               last;
   } sample_type;

   // one integral as the block should report it
   typedef struct {
      s64_type integral;
      logic    zero;
      logic    sat;
   } integral_type;

   localparam int  SETTLE_CYCLES = 800;
   localparam longint CYCLE_LIMIT = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_sample_value = '0;
   logic signed [31:0] req_position = '0;
   logic               req_last_sample = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [63:0] rsp_integral;
   logic               rsp_zero_spacing;
   logic               rsp_saturated;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = CSR_USE_POSITIONS;
   logic [31:0]        csr_wr_data = '0;

   simpson_integrator_uneven dut (.*);

   always #2 clock = ~clock;

   // requests still to send, integrals still to receive
   sample_type   pending_samples[$];
   integral_type awaited_integrals[$];
   int        samples_pushed = 0;
   int        samples_taken = 0;
   int        errors = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   longint    cycle_count = 0;

   // mirror of the config registers
   logic        mode_positions = 1'b0;
   logic [31:0] mode_spacing = SPACING_RESET;

   // mirror of the stream state
   s64_type win_y[2];
   s64_type win_h[2];
   s64_type prev_pos;
   int   seen;
   logic parity;
   s64_type running;
   logic mark_zero, mark_sat;
   logic step_sat, step_zero;

   // (a*b << k) / d, truncated toward zero, clamped to 64 bits; zero when d is zero
   function automatic s64_type mul_shift_div(s64_type a, s64_type b, int k, s64_type d);
      logic [63:0]  ua, ub, ud, lim;
      logic [127:0] prod, quo;
      logic         neg;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      ud = d[63] ? -d : d;
      neg = (a[63] ^ b[63]) ^ d[63];
      if (ud == 0) return 0;
      prod = {64'd0, ua} * {64'd0, ub};
      if (k > 0) begin
         if ((prod >> (128 - k)) != 0) begin
            step_sat = 1'b1;
            return neg ? INT64_MIN : INT64_MAX;
         end
         prod = prod << k;
      end
      quo = prod / {64'd0, ud};
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (quo[127:64] != 0 || quo[63:0] > lim) begin
         step_sat = 1'b1;
         return neg ? INT64_MIN : INT64_MAX;
      end
      return neg ? -quo[63:0] : quo[63:0];
   endfunction

   function automatic s64_type clamp_add(s64_type a, s64_type b);
      s64_type s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         step_sat = 1'b1;
         return a[63] ? INT64_MIN : INT64_MAX;
      end
      return s;
   endfunction

   function automatic s64_type clamp_sub(s64_type a, s64_type b);
      if (b == INT64_MIN) begin
         step_sat = 1'b1;
         return a[63] ? a + INT64_MIN : INT64_MAX;
      end
      return clamp_add(a, -b);
   endfunction

   function automatic s64_type weighted(s64_type w, s64_type y);
      return mul_shift_div(w, y, 0, s64_type'(1) << FRAC_BITS);
   endfunction

   // simpson term over two uneven intervals
   function automatic s64_type simpson_pair(s64_type h0, s64_type h1, s64_type y0,
                                            s64_type y1, s64_type y2);
      s64_type s, w0, w1, w2;
      s = h0 + h1;
      if (h0 == 0 || h1 == 0) begin
         step_zero = 1'b1;
         return 0;
      end
      w0 = mul_shift_div(s, 2 * h0 - h1, K_SHIFT, 6 * h0);
      w2 = mul_shift_div(s, 2 * h1 - h0, K_SHIFT, 6 * h1);
      w1 = clamp_sub(clamp_sub(mul_shift_div(s, 1, K_SHIFT, 1), w0), w2);
      return clamp_add(clamp_add(weighted(w0, y0), weighted(w1, y1)), weighted(w2, y2));
   endfunction

   // parabolic correction for a final odd interval
   function automatic s64_type tail_correction(s64_type h0, s64_type h1, s64_type y0,
                                               s64_type y1, s64_type y2);
      s64_type s, v0, v1, v2;
      s = h0 + h1;
      if (h0 == 0 || s == 0) begin
         step_zero = 1'b1;
         return 0;
      end
      v2 = mul_shift_div(h1, 2 * h1 + 3 * h0, K_SHIFT, 6 * s);
      v1 = mul_shift_div(h1, h1 + 3 * h0, K_SHIFT, 6 * h0);
      v0 = clamp_sub(clamp_add(v2, v1), mul_shift_div(h1, 1, K_SHIFT, 1));
      return clamp_sub(clamp_add(weighted(v2, y2), weighted(v1, y1)), weighted(v0, y0));
   endfunction

   task automatic clear_stream();
      win_y = '{0, 0};
      win_h = '{0, 0};
      prev_pos = 0;
      seen = 0;
      parity = 1'b0;
      running = 0;
      mark_zero = 1'b0;
      mark_sat = 1'b0;
   endtask

   // advance the integrator mirror by one accepted request
   task automatic integrate_sample(sample_type smp);
      s64_type y, pos, h, term;
      integral_type res;
      y = smp.value;
      pos = smp.pos;
      term = 0;
      step_sat = 1'b0;
      step_zero = 1'b0;
      if (seen == 0) begin
         win_y[1] = y;
         prev_pos = pos;
         seen = 1;
      end else begin
         h = mode_positions ? pos - prev_pos : s64_type'({32'd0, mode_spacing});
         prev_pos = pos;
         parity = ~parity;
         if (seen >= 2 && !parity)
            term = simpson_pair(win_h[1], h, win_y[0], win_y[1], y);
         if (smp.last && parity) begin
            if (seen == 1)
               term = mul_shift_div(win_y[1] + y, h, K_SHIFT,
                                    s64_type'(1) << (FRAC_BITS + 1));
            else
               term = tail_correction(win_h[1], h, win_y[0], win_y[1], y);
         end
         running = clamp_add(running, term);
         win_y[0] = win_y[1];
         win_y[1] = y;
         win_h[0] = win_h[1];
         win_h[1] = h;
         if (seen < 3) seen++;
      end
      mark_zero |= step_zero;
      mark_sat |= step_sat;
      if (smp.last) begin
         res.integral = running;
         res.zero = mark_zero;
         res.sat = mark_sat;
         awaited_integrals.insert(awaited_integrals.size(), res);
         clear_stream();
      end
   endtask

   // driver: holds a request until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_stream();
      end else begin
         if (req_valid && !req_stall) begin
            integrate_sample('{req_sample_value, req_position, req_last_sample});
            samples_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               sample_type nxt;
               nxt = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_sample_value <= nxt.value;
               req_position <= nxt.pos;
               req_last_sample <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each integral against the oldest one awaited
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_integrals.size() == 0) begin
               errors++;
               $display("%0t: unexpected integral %h", $realtime, rsp_integral);
            end else begin
               integral_type exp_res;
               exp_res = awaited_integrals.pop_front();
               if (rsp_integral !== exp_res.integral) begin
                  errors++;
                  $display("%0t: integral expected %h got %h", $realtime,
                           exp_res.integral, rsp_integral);
               end
               if (rsp_zero_spacing !== exp_res.zero) begin
                  errors++;
                  $display("%0t: zero_spacing expected %b got %b", $realtime,
                           exp_res.zero, rsp_zero_spacing);
               end
               if (rsp_saturated !== exp_res.sat) begin
                  errors++;
                  $display("%0t: saturated expected %b got %b", $realtime,
                           exp_res.sat, rsp_saturated);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_sample(logic signed [31:0] value, logic signed [31:0] pos,
                              logic last);
      sample_type smp;
      smp.value = value;
      smp.pos = pos;
      smp.last = last;
      pending_samples.insert(pending_samples.size(), smp);
      samples_pushed++;
   endtask

   // wait until every request is taken, every integral is in and the datapath is quiet
   task automatic drain();
      wait (samples_taken == samples_pushed && awaited_integrals.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_USE_POSITIONS) mode_positions = data[0];
      else mode_spacing = data;
   endtask

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2, 3: return $signed($urandom_range(8 << 16)) - (4 << 16);
         4:    return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      endcase
   endfunction

   // next abscissa: mostly small forward steps, sometimes repeated,
   // backward or anywhere at all
   function automatic logic signed [31:0] next_pos(logic signed [31:0] pos);
      case ($urandom_range(19))
         0:       return pos;
         1, 2:    return pos - $signed($urandom_range(3 << 16));
         3:       return $urandom;
         default: return pos + $signed($urandom_range(3 << 16, 1));
      endcase
   endfunction

   // one data set of random length and content
   task automatic push_data_set();
      int len;
      logic signed [31:0] pos;
      len = ($urandom_range(19) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      pos = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(1 << 20)) - (1 << 19);
      for (int i = 0; i < len; i++) begin
         push_sample(rand_value(), pos, i == len - 1);
         pos = next_pos(pos);
      end
   endtask

   task automatic random_sets(int count);
      int start;
      start = samples_pushed;
      while (samples_pushed - start < count) push_data_set();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed, uniform unit spacing: one to five samples, extremes of the fields
      send_idle_pct = 24;
      recv_stall_pct = 65;
      push_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      push_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      push_sample(32'sh7FFF_FFFF, -32'sd1, 1'b1);
      push_sample(32'sd1 << 16, 0, 1'b0);
      push_sample(32'sd2 << 16, 0, 1'b0);
      push_sample(32'sd3 << 16, 0, 1'b1);
      push_sample(32'sh7FFF_FFFF, 0, 1'b0);
      push_sample(32'sh7FFF_FFFF, 0, 1'b0);
      push_sample(32'sh8000_0000, 0, 1'b0);
      push_sample(32'sh7FFF_FFFF, 0, 1'b1);
      push_sample(-32'sd1, 0, 1'b0);
      push_sample(32'sd5 << 16, 0, 1'b0);
      push_sample(-(32'sd7 << 16), 0, 1'b0);
      push_sample(32'sd0, 0, 1'b0);
      push_sample(32'sd9 << 16, 0, 1'b1);
      random_sets(220);
      drain();

      // positions mode, including a mode switch in the middle of an open set
      write_csr(CSR_USE_POSITIONS, 32'd1);
      push_sample(32'sd1 << 16, 32'sd0, 1'b0);
      push_sample(32'sd4 << 16, 32'sd1 << 15, 1'b0);
      push_sample(-(32'sd2 << 16), 32'sd3 << 16, 1'b0);
      drain();
      write_csr(CSR_USE_POSITIONS, 32'd0);
      push_sample(32'sd6 << 16, 32'sd0, 1'b0);
      push_sample(32'sd1 << 16, 32'sd0, 1'b1);
      drain();
      write_csr(CSR_USE_POSITIONS, 32'd1);
      push_sample(32'sd1 << 16, 32'sd5 << 16, 1'b0);
      push_sample(32'sd1 << 16, 32'sd5 << 16, 1'b0);
      push_sample(32'sd1 << 16, 32'sd2 << 16, 1'b1);
      random_sets(240);
      drain();

      // zero uniform spacing
      send_idle_pct = 65;
      recv_stall_pct = 24;
      write_csr(CSR_USE_POSITIONS, 32'd0);
      write_csr(CSR_UNIFORM_SPACING, 32'd0);
      random_sets(150);
      drain();

      // widest uniform spacing drives sums into saturation
      write_csr(CSR_UNIFORM_SPACING, 32'hFFFF_FFFF);
      random_sets(150);
      drain();

      // no idling: positions mode, then a random small uniform spacing
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(CSR_USE_POSITIONS, 32'd1);
      random_sets(330);
      drain();
      write_csr(CSR_USE_POSITIONS, 32'd0);
      write_csr(CSR_UNIFORM_SPACING, $urandom_range(1 << 18, 1));
      random_sets(330);
      drain();

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
